// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEFF_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TOL_WIDTH   = 16;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INF  = 2'd1,
        KIND_ONE  = 2'd2,
        KIND_TWO  = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [COEFF_WIDTH-1:0] coeff_square;
        logic signed [COEFF_WIDTH-1:0] coeff_linear;
        logic signed [COEFF_WIDTH-1:0] coeff_constant;
    } in_t;

    typedef struct packed {
        kind_t                         root_kind;
        logic signed [COEFF_WIDTH-1:0] first_root;
        logic signed [COEFF_WIDTH-1:0] second_root;
        logic                          root_saturated;
    } out_t;

endpackage

// ===== rtl/core/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int VW     = 66,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [VW-1:0]     in_value,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [VW/2-1:0]   out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int R  = VW / 2;
    localparam int RW = R + 3;

    logic              valid_reg [R];
    logic [RW-1:0]     rem_reg   [R];
    logic [R-1:0]      root_reg  [R];
    logic [VW-1:0]     val_reg   [R];
    logic [SIDE_W-1:0] side_reg  [R];

    genvar k;
    for (k = 0; k < R; k++) begin : g_stage
        logic              valid_prev;
        logic [RW-1:0]     rem_prev;
        logic [R-1:0]      root_prev;
        logic [VW-1:0]     val_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     rem_next;
        logic [R-1:0]      root_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign val_prev   = in_value;
            assign side_prev  = in_side;
        end
        else begin : g_next
            assign valid_prev = valid_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign root_prev  = root_reg[k-1];
            assign val_prev   = val_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev[RW-3:0], val_prev[VW-1 -: 2]};
            trial  = {1'b0, root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[R-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                val_reg[k]  <= val_prev << 2;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[R-1];
    assign out_root  = root_reg[R-1];
    assign out_side  = side_reg[R-1];

endmodule

// ===== rtl/core/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider, shared divisor, one quotient bit
// per stage. Each lane computes (num << FRAC) / den.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int NW     = 34,
    parameter int DW     = 33,
    parameter int FRAC   = 16,
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [1:0][NW-1:0]        in_num,
    input  logic [DW-1:0]             in_den,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [1:0][NW+FRAC-1:0]   out_quot,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int N = NW + FRAC;

    logic                 valid_reg [N];
    logic [1:0][N-1:0]    x_reg     [N];
    logic [1:0][DW-1:0]   rem_reg   [N];
    logic [DW-1:0]        den_reg   [N];
    logic [SIDE_W-1:0]    side_reg  [N];

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        logic               valid_prev;
        logic [1:0][N-1:0]  x_prev;
        logic [1:0][DW-1:0] rem_prev;
        logic [DW-1:0]      den_prev;
        logic [SIDE_W-1:0]  side_prev;
        logic [1:0][N-1:0]  x_next;
        logic [1:0][DW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign valid_prev = in_valid;
            assign x_prev     = {{in_num[1], FRAC'(0)}, {in_num[0], FRAC'(0)}};
            assign rem_prev   = '0;
            assign den_prev   = in_den;
            assign side_prev  = in_side;
        end
        else begin : g_next
            assign valid_prev = valid_reg[k-1];
            assign x_prev     = x_reg[k-1];
            assign rem_prev   = rem_reg[k-1];
            assign den_prev   = den_reg[k-1];
            assign side_prev  = side_reg[k-1];
        end

        always_comb
        begin
            logic [DW:0] rem_sh;
            for (int l = 0; l < 2; l++)
            begin
                rem_sh = {rem_prev[l], x_prev[l][N-1]};
                if (rem_sh >= {1'b0, den_prev})
                begin
                    rem_next[l] = DW'(rem_sh - {1'b0, den_prev});
                    x_next[l]   = {x_prev[l][N-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_sh[DW-1:0];
                    x_next[l]   = {x_prev[l][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quot  = x_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== rtl/core/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 on signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient beat is accepted every cycle while the
// output is not stalled, with Q16.16 coefficients and roots by default.
// The pipeline depth is dominated by the bit-serial square root (COEFF_WIDTH+1
// stages) and the divider (COEFF_WIDTH+2+FRAC_BITS stages). The whole
// pipeline holds while the output beat waits on out_ready. zero_tolerance
// is written through cfg_wr_en/cfg_wr_data and must only change while the
// pipeline is empty.
module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]  cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  qrs_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output qrs_pkg::out_t                  out_data
);

    localparam int W  = qrs_pkg::COEFF_WIDTH;
    localparam int TW = qrs_pkg::TOL_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int W2 = 2 * H;
    localparam int PW = 2 * W2;
    localparam int VW = 2 * W + 2;
    localparam int R  = VW / 2;
    localparam int NW = W + 2;
    localparam int DW = W + 1;
    localparam int N  = NW + FRAC_BITS;
    localparam int CW = (VW > TW + FRAC_BITS) ? VW : TW + FRAC_BITS;

    typedef struct packed {
        qrs_pkg::kind_t kind;
        logic           lin;
        logic           an;
        logic [W-1:0]   am;
        logic           bn;
        logic [W-1:0]   bm;
        logic           cn;
        logic [W-1:0]   cm;
    } side_t;

    typedef struct packed {
        qrs_pkg::kind_t kind;
        logic           neg1;
        logic           neg2;
    } dside_t;

    logic          en;
    logic [TW-1:0] tol_reg;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    // decode
    logic         s1_valid_reg;
    side_t        s1_reg;
    side_t        s1_next;

    always_comb
    begin
        logic [W-1:0] a_raw;
        logic [W-1:0] b_raw;
        logic [W-1:0] c_raw;
        logic         az;
        logic         bz;
        logic         cz;
        a_raw      = in_data.coeff_square;
        b_raw      = in_data.coeff_linear;
        c_raw      = in_data.coeff_constant;
        s1_next.an = a_raw[W-1];
        s1_next.bn = b_raw[W-1];
        s1_next.cn = c_raw[W-1];
        s1_next.am = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
        s1_next.bm = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;
        s1_next.cm = c_raw[W-1] ? (~c_raw + W'(1)) : c_raw;
        az = s1_next.am <= W'(tol_reg);
        bz = s1_next.bm <= W'(tol_reg);
        cz = s1_next.cm <= W'(tol_reg);
        s1_next.lin = az;
        if (bz && cz)
            s1_next.kind = qrs_pkg::KIND_INF;
        else if (bz)
            s1_next.kind = qrs_pkg::KIND_NONE;
        else
            s1_next.kind = qrs_pkg::KIND_ONE;
    end

    // partial products
    logic            m1_valid_reg;
    side_t           m1_side_reg;
    logic [W2-1:0]   pp_bhh_reg, pp_bhl_reg, pp_bll_reg;
    logic [W2-1:0]   pp_ahh_reg, pp_ahl_reg, pp_alh_reg, pp_all_reg;
    logic [W2-1:0]   amx, bmx, cmx;

    assign amx = W2'(s1_reg.am);
    assign bmx = W2'(s1_reg.bm);
    assign cmx = W2'(s1_reg.cm);

    // product sums
    logic            m2_valid_reg;
    side_t           m2_side_reg;
    logic [2*W-1:0]  bb_reg, ac_reg;
    logic [PW-1:0]   bb_full, ac_full;

    assign bb_full = (PW'(pp_bhh_reg) << W2) + (PW'(pp_bhl_reg) << (H + 1))
                   + PW'(pp_bll_reg);
    assign ac_full = (PW'(pp_ahh_reg) << W2) + (PW'(pp_ahl_reg) << H)
                   + (PW'(pp_alh_reg) << H) + PW'(pp_all_reg);

    // discriminant
    logic            d_valid_reg;
    side_t           d_side_reg;
    logic [VW-1:0]   dmag_reg;
    logic            dneg_reg;
    logic [VW-1:0]   dmag_next;
    logic            dneg_next;

    always_comb
    begin
        logic [VW-1:0] fac;
        logic [VW-1:0] bbx;
        fac = {ac_reg, 2'b00};
        bbx = VW'(bb_reg);
        if (m2_side_reg.an != m2_side_reg.cn)
        begin
            dneg_next = 1'b0;
            dmag_next = bbx + fac;
        end
        else if (fac <= bbx)
        begin
            dneg_next = 1'b0;
            dmag_next = bbx - fac;
        end
        else
        begin
            dneg_next = 1'b1;
            dmag_next = fac - bbx;
        end
    end

    side_t sq_side_in;

    always_comb
    begin
        logic dzero;
        dzero      = CW'(dmag_reg) <= (CW'(tol_reg) << FRAC_BITS);
        sq_side_in = d_side_reg;
        if (!d_side_reg.lin)
        begin
            if (dzero)
                sq_side_in.kind = qrs_pkg::KIND_ONE;
            else if (!dneg_reg)
                sq_side_in.kind = qrs_pkg::KIND_TWO;
            else
                sq_side_in.kind = qrs_pkg::KIND_NONE;
        end
    end

    logic          sq_valid;
    logic [R-1:0]  sq_root;
    side_t         sq_side;

    qrs_sqrt #(
        .VW     (VW),
        .SIDE_W ($bits(side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .in_value  (dmag_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // numerators and divisor
    function automatic logic [NW:0] sm_add(input logic n1, input logic [NW-1:0] m1,
                                           input logic n2, input logic [NW-1:0] m2);
        logic [NW:0] res;
        if (n1 == n2)
            res = {n1, m1 + m2};
        else if (m1 >= m2)
            res = {n1, m1 - m2};
        else
            res = {n2, m2 - m1};
        return res;
    endfunction

    logic              nm_valid_reg;
    logic [1:0][NW-1:0] nm_num_reg;
    logic [DW-1:0]     nm_den_reg;
    dside_t            nm_side_reg;
    logic [1:0][NW-1:0] nm_num_next;
    logic [DW-1:0]     nm_den_next;
    dside_t            nm_side_next;

    always_comb
    begin
        logic [NW:0] l1;
        logic [NW:0] l2;
        logic        dn;
        if (sq_side.lin)
        begin
            l1          = {!sq_side.cn, NW'(sq_side.cm)};
            l2          = l1;
            dn          = sq_side.bn;
            nm_den_next = DW'(sq_side.bm);
        end
        else
        begin
            dn          = sq_side.an;
            nm_den_next = {sq_side.am, 1'b0};
            if (sq_side.kind == qrs_pkg::KIND_TWO)
            begin
                l1 = sm_add(!sq_side.bn, NW'(sq_side.bm), 1'b0, NW'(sq_root));
                l2 = sm_add(!sq_side.bn, NW'(sq_side.bm), 1'b1, NW'(sq_root));
            end
            else
            begin
                l1 = {!sq_side.bn, NW'(sq_side.bm)};
                l2 = l1;
            end
        end
        nm_num_next[0]    = l1[NW-1:0];
        nm_num_next[1]    = l2[NW-1:0];
        nm_side_next.kind = sq_side.kind;
        nm_side_next.neg1 = l1[NW] ^ dn;
        nm_side_next.neg2 = l2[NW] ^ dn;
    end

    logic              dv_valid;
    logic [1:0][N-1:0] dv_quot;
    dside_t            dv_side;

    qrs_div #(
        .NW     (NW),
        .DW     (DW),
        .FRAC   (FRAC_BITS),
        .SIDE_W ($bits(dside_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid_reg),
        .in_num    (nm_num_reg),
        .in_den    (nm_den_reg),
        .in_side   (nm_side_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // clamp, sign and output register
    logic          out_valid_reg;
    qrs_pkg::out_t out_reg;
    qrs_pkg::out_t out_next;

    always_comb
    begin
        logic [N-1:0] limit;
        logic [W-1:0] mag;
        logic [1:0]   sat;
        logic [1:0]   neg;
        logic [1:0][W-1:0] res;
        neg = {dv_side.neg2, dv_side.neg1};
        for (int l = 0; l < 2; l++)
        begin
            limit  = (N'(1) << (W - 1)) - N'(!neg[l]);
            sat[l] = dv_quot[l] > limit;
            mag    = sat[l] ? limit[W-1:0] : dv_quot[l][W-1:0];
            res[l] = neg[l] ? (~mag + W'(1)) : mag;
        end
        out_next.root_kind = dv_side.kind;
        if (dv_side.kind == qrs_pkg::KIND_ONE || dv_side.kind == qrs_pkg::KIND_TWO)
        begin
            out_next.first_root     = res[0];
            out_next.second_root    = res[1];
            out_next.root_saturated = |sat;
        end
        else
        begin
            out_next.first_root     = '0;
            out_next.second_root    = '0;
            out_next.root_saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            d_valid_reg   <= 1'b0;
            nm_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            m1_valid_reg  <= s1_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            d_valid_reg   <= m2_valid_reg;
            nm_valid_reg  <= sq_valid;
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= s1_next;
            m1_side_reg <= s1_reg;
            pp_bhh_reg  <= bmx[W2-1:H] * bmx[W2-1:H];
            pp_bhl_reg  <= bmx[W2-1:H] * bmx[H-1:0];
            pp_bll_reg  <= bmx[H-1:0] * bmx[H-1:0];
            pp_ahh_reg  <= amx[W2-1:H] * cmx[W2-1:H];
            pp_ahl_reg  <= amx[W2-1:H] * cmx[H-1:0];
            pp_alh_reg  <= amx[H-1:0] * cmx[W2-1:H];
            pp_all_reg  <= amx[H-1:0] * cmx[H-1:0];
            m2_side_reg <= m1_side_reg;
            bb_reg      <= bb_full[2*W-1:0];
            ac_reg      <= ac_full[2*W-1:0];
            d_side_reg  <= m2_side_reg;
            dmag_reg    <= dmag_next;
            dneg_reg    <= dneg_next;
            nm_num_reg  <= nm_num_next;
            nm_den_reg  <= nm_den_next;
            nm_side_reg <= nm_side_next;
            out_reg     <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
